### hdl/midi_message_assembler_top_assert.svh
// ----------------------------------------------------------------------------
// MIDI message assembler assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MIDI_MESSAGE_ASSEMBLER_TOP_ASSERT_SVH
`define MIDI_MESSAGE_ASSEMBLER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/mma_pkg.sv
// ----------------------------------------------------------------------------
// MIDI message assembler package
// Byte constants, message length codes and the status length table.
// ----------------------------------------------------------------------------
package mma_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_len;

    localparam t_byte SYSEX_START = 8'hF0;
    localparam t_byte SYSEX_END   = 8'hF7;
    localparam t_byte NO_STATUS   = 8'h0F;

    localparam t_len LEN_NONE  = 2'd0;
    localparam t_len LEN_ONE   = 2'd1;
    localparam t_len LEN_TWO   = 2'd2;
    localparam t_len LEN_THREE = 2'd3;

    // Message length for a status byte; zero marks an undefined status or a SysEx start or end byte.
    function automatic t_len status_length(input t_byte s);
        t_len len;
        case (s[7:4]) inside
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = LEN_THREE;
            4'hC, 4'hD:                   len = LEN_TWO;
            4'hF: begin
                case (s[3:0]) inside
                    4'h2:                                 len = LEN_THREE;
                    4'h1, 4'h3:                           len = LEN_TWO;
                    4'h6, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE,
                    4'hF:                                 len = LEN_ONE;
                    default:                              len = LEN_NONE;
                endcase
            end
            default:                      len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage

### hdl/midi_message_assembler_top.sv
// ----------------------------------------------------------------------------
// MIDI message assembler
// Gathers received MIDI bytes into complete messages with running status.
// ----------------------------------------------------------------------------
// Input channel: one received byte per beat on i_rx_byte (i_rx_valid /
// o_rx_ready). Output channel: one complete message per beat (o_msg_valid /
// i_msg_ready) with its status byte, up to two data bytes (zero where the
// message is shorter) and its length of one to three bytes.
// A byte is captured in an input register and processed from there; a message
// it completes is then registered in the output register.
// Throughput is one byte per cycle while the output is not stalled: the parser
// state updates as each byte is processed, so the next byte may follow directly.
// Bytes that complete nothing (data awaiting more, SysEx contents, dropped
// bytes) give no output beat.
// Reset clears the parser to idle with no usable running status and empties
// both registers. When the receiver stalls, the finished message holds in the
// output register; the input register then holds one byte and o_rx_ready
// drops until the message is taken.
// ----------------------------------------------------------------------------
module midi_message_assembler_top
    import mma_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_msg_valid,
    input  logic       i_msg_ready,
    output logic [7:0] o_status_byte,
    output logic [7:0] o_data_one,
    output logic [7:0] o_data_two,
    output logic [1:0] o_msg_length
);

    // Input register.
    logic  r_in_valid;
    t_byte r_in_byte;

    // Parser state.
    t_byte r_running;
    t_byte r_msg [3];
    t_len  r_fill;
    t_len  r_left;
    logic  r_in_sysex;
    logic  r_msg_ok;

    t_byte n_running;
    t_byte n_msg [3];
    t_len  n_fill;
    t_len  n_left;
    logic  n_in_sysex;
    logic  n_msg_ok;
    logic  n_emit;

    // Output register.
    logic  r_out_valid;
    t_byte r_out_status;
    t_byte r_out_one;
    t_byte r_out_two;
    t_len  r_out_len;

    logic  advance;
    t_len  rs_len;
    t_len  b_len;

    assign advance    = r_in_valid && (!r_out_valid || i_msg_ready);
    assign o_rx_ready = !r_in_valid || advance;
    assign rs_len     = status_length(r_running);
    assign b_len      = status_length(r_in_byte);

    always_comb begin
        n_running  = r_running;
        n_msg      = r_msg;
        n_fill     = r_fill;
        n_left     = r_left;
        n_in_sysex = r_in_sysex;
        n_msg_ok   = r_msg_ok;
        n_emit     = 1'b0;

        if (r_in_sysex) begin
            if (r_in_byte == SYSEX_END) begin
                n_in_sysex = 1'b0;
                n_fill     = LEN_NONE;
                n_left     = LEN_NONE;
            end
        end else if (r_fill == LEN_NONE) begin
            if (r_in_byte[7]) begin
                n_running  = r_in_byte;
                n_in_sysex = (r_in_byte == SYSEX_START);
                if (b_len == LEN_NONE) begin
                    n_msg_ok = 1'b0;
                    n_left   = LEN_NONE;
                end else begin
                    n_msg_ok = 1'b1;
                    n_msg[0] = r_in_byte;
                    n_fill   = LEN_ONE;
                    n_left   = b_len - LEN_ONE;
                    n_emit   = (n_left == LEN_NONE);
                end
            end else if (rs_len == LEN_TWO || rs_len == LEN_THREE) begin
                // Running status: the stored status opens the message.
                n_msg_ok = 1'b1;
                n_msg[0] = r_running;
                n_msg[1] = r_in_byte;
                n_fill   = LEN_TWO;
                n_left   = rs_len - LEN_TWO;
                n_emit   = (n_left == LEN_NONE);
            end
        end else begin
            // Mid-message, any byte (status bytes too) is taken as data.
            if (r_fill != LEN_THREE) begin
                n_msg[r_fill] = r_in_byte;
                n_fill        = r_fill + LEN_ONE;
            end
            if (r_left != LEN_NONE) begin
                n_left = r_left - LEN_ONE;
            end
            n_emit = (n_left == LEN_NONE) && r_msg_ok && (n_fill != LEN_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= NO_STATUS;
            r_fill     <= LEN_NONE;
            r_left     <= LEN_NONE;
            r_in_sysex <= 1'b0;
            r_msg_ok   <= 1'b0;
        end else if (advance) begin
            r_running  <= n_running;
            r_fill     <= n_emit ? LEN_NONE : n_fill;
            r_left     <= n_left;
            r_in_sysex <= n_in_sysex;
            r_msg_ok   <= n_msg_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_msg <= n_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_msg_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_emit) begin
            r_out_status <= n_msg[0];
            r_out_one    <= (n_fill == LEN_TWO || n_fill == LEN_THREE) ? n_msg[1] : '0;
            r_out_two    <= (n_fill == LEN_THREE) ? n_msg[2] : '0;
            r_out_len    <= n_fill;
        end
    end

    assign o_msg_valid   = r_out_valid;
    assign o_status_byte = r_out_status;
    assign o_data_one    = r_out_one;
    assign o_data_two    = r_out_two;
    assign o_msg_length  = r_out_len;

`include "midi_message_assembler_top_assert.svh"

    `MMA_ASSERT_NOW(a_partial_is_defined, r_fill != LEN_NONE,
        r_msg_ok && !r_in_sysex, "partial message without a defined status")
    `MMA_ASSERT_NOW(a_sysex_idle, r_in_sysex, r_fill == LEN_NONE,
        "SysEx discard with a partial message pending")
    `MMA_ASSERT_NOW(a_short_msg_zero, o_msg_valid && o_msg_length == LEN_ONE,
        o_data_one == '0 && o_data_two == '0 && o_status_byte[7],
        "one-byte message with nonzero data")
    `MMA_ASSERT_NEXT(a_no_emit_on_drop,
        advance && r_fill == LEN_NONE && !r_in_sysex && !r_in_byte[7]
            && !(rs_len == LEN_TWO || rs_len == LEN_THREE),
        r_fill == LEN_NONE && r_running == $past(r_running),
        "dropped data byte changed the parser state")

endmodule
